@@ hdl/agfr_pkg.sv @@
`timescale 1ns / 1ps
// Package for the audio gain fade ramp: field widths, payload structs, register
// indexes, opcodes and the request/response structs of the serial divider.
// No dependencies.
package agfr_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int GAIN_FRAC_BITS = 32;
   localparam int GAIN_BITS      = GAIN_FRAC_BITS + 1;
   localparam int STEP_BITS      = GAIN_FRAC_BITS + 2;
   localparam int FRAME_BITS     = 32;
   localparam int MAX_CHANNELS   = 8;
   localparam int POS_BITS       = 3;
   localparam int CHAN_BITS      = 4;
   localparam int RATE_BITS      = 18;
   localparam int VOL_BITS       = 17;
   localparam int TGT_BITS       = 17;
   localparam int MS_BITS        = 16;

   localparam logic [VOL_BITS-1:0]  UNITY_Q16 = 17'd65536;
   localparam logic [GAIN_BITS-1:0] GAIN_ONE  = 33'h1_0000_0000;
   localparam int MS_PER_S = 1000;

   // Fade length: rate*ms/1000 = ((rate*ms) >> 3) / 125, with the division done as
   // a multiplication by ceil(2^38 / 125), which is exact for dividends below 2^31.
   localparam logic [31:0] FRAME_RECIP       = 32'h8312_6E98;
   localparam int          FRAME_RECIP_SHIFT = 38;

   // Shared multiplier operand widths.
   localparam int MUL_A_BITS = 24;
   localparam int MUL_B_BITS = 17;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

   // Serial divider: dividend and divisor widths, step counter width.
   localparam int DIV_WIDTH    = 34;
   localparam int DVS_WIDTH    = 32;
   localparam int DIV_CNT_BITS = 6;

   // Configuration port.
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 18;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SAMPLE_RATE = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHANNELS    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MASTER_VOL  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MUTED       = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PLAYING     = 3'd4;

   localparam logic OP_SAMPLE     = 1'b0;
   localparam logic OP_SET_TARGET = 1'b1;

   typedef struct packed {
      logic                          opcode;
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic [TGT_BITS-1:0]           target_gain;
      logic [MS_BITS-1:0]            fade_ms;
   } agfr_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          frame_last;
      logic                          ramp_active;
   } agfr_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_WIDTH-1:0] dividend;
      logic [DVS_WIDTH-1:0] divisor;
   } agfr_div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_WIDTH-1:0] quotient;
   } agfr_div_rsp_type;

endpackage

@@ hdl/agfr_div.sv @@
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle, for the fade setup.
// Depends on agfr_pkg.
module agfr_div (
   input  logic                       clock,
   input  logic                       reset,
   input  agfr_pkg::agfr_div_req_type div_req,
   output agfr_pkg::agfr_div_rsp_type div_rsp
);
   import agfr_pkg::*;

   logic [DVS_WIDTH-1:0]    rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]    quo_ff, quo_in;
   logic [DVS_WIDTH-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    done_ff, done_in;

   logic [DVS_WIDTH:0] shifted;
   logic [DVS_WIDTH:0] trial;
   logic               fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_WIDTH-1]};
      trial   = shifted - {1'b0, dvs_ff};
      fits    = shifted >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in = '0;
         quo_in = div_req.dividend;
         dvs_in = div_req.divisor;
         cnt_in = DIV_CNT_BITS'(DIV_WIDTH);
      end else if (cnt_ff != '0) begin
         // The partial remainder stays below the divisor, so it fits its width.
         rem_in  = fits ? trial[DVS_WIDTH-1:0] : shifted[DVS_WIDTH-1:0];
         quo_in  = {quo_ff[DIV_WIDTH-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = cnt_ff == DIV_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ hdl/audio_gain_fade_ramp.sv @@
`timescale 1ns / 1ps
// Audio gain fade ramp: scales interleaved samples by master volume times a
// linearly fading gain, and sets new fade targets. Depends on agfr_pkg, agfr_div.
//
// Requests arrive on req_valid/req_ready with an agfr_req_type payload. A sample
// request gives one response on rsp_valid/rsp_ready; a set-target request gives
// none. Registers are written through csr_we/csr_index/csr_wdata, by the user
// only while idle; the block itself does not enforce this. A sample request is
// taken in the idle state; then one 24x17 multiplier forms master volume times
// gain in two partial products and the sample times that gain in two more, and
// the last step loads the response into the output register. For a set-target
// request with a fade, the fade length rate*ms/1000 comes from a reciprocal
// multiplication in four partial products on the same multiplier, and the
// per-frame step (gain difference / frames) from one 34-step pass through the
// serial divider. A set-target request with zero fade time takes effect in the
// idle state that accepts it. req_ready is high only while idle.
// A response waiting in the output register does not block the next request;
// if the receiver stalls, a following sample waits in its last step until the
// output register is free. Reset, synchronous and active high, loads the
// default registers, clears the gain state and empties the output register.
module audio_gain_fade_ramp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  agfr_pkg::agfr_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output agfr_pkg::agfr_rsp_type               rsp_data,
   input  logic                                 csr_we,
   input  logic [agfr_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [agfr_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import agfr_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FMUL  = 4'd1;
   localparam logic [3:0] ST_FLD   = 4'd2;
   localparam logic [3:0] ST_FR0   = 4'd3;
   localparam logic [3:0] ST_FR1   = 4'd4;
   localparam logic [3:0] ST_FR2   = 4'd5;
   localparam logic [3:0] ST_FR3   = 4'd6;
   localparam logic [3:0] ST_FR4   = 4'd7;
   localparam logic [3:0] ST_SWAIT = 4'd8;
   localparam logic [3:0] ST_G0    = 4'd9;
   localparam logic [3:0] ST_G1    = 4'd10;
   localparam logic [3:0] ST_G2    = 4'd11;
   localparam logic [3:0] ST_M0    = 4'd12;
   localparam logic [3:0] ST_M1    = 4'd13;
   localparam logic [3:0] ST_M2    = 4'd14;
   localparam logic [3:0] ST_OUT   = 4'd15;

   logic [3:0]             state_ff, state_in;
   logic [RATE_BITS-1:0]   rate_ff, rate_in;
   logic [CHAN_BITS-1:0]   chan_ff, chan_in;
   logic [VOL_BITS-1:0]    vol_ff, vol_in;
   logic                   muted_ff, muted_in;
   logic                   playing_ff, playing_in;

   logic [GAIN_BITS-1:0]   cur_ff, cur_in;
   logic [GAIN_BITS-1:0]   target_ff, target_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [FRAME_BITS-1:0]  frames_ff, frames_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;

   logic [GAIN_BITS-1:0]   newt_ff, newt_in;
   logic [MS_BITS-1:0]     ms_ff, ms_in;
   logic [FRAME_BITS-1:0]  newf_ff, newf_in;
   logic [30:0]            fnum_ff, fnum_in;
   logic [63:0]            facc_ff, facc_in;
   logic                   sneg_ff, sneg_in;
   logic [SAMPLE_BITS-1:0] mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [PROD_BITS-1:0]   acc_ff, acc_in;
   logic [GAIN_BITS-1:0]   g_ff, g_in;
   logic [SAMPLE_BITS-1:0] y_ff, y_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   agfr_rsp_type           rsp_data_ff, rsp_data_in;

   agfr_div_req_type       div_req;
   agfr_div_rsp_type       div_rsp;

   logic [MUL_A_BITS-1:0]  mul_a;
   logic [MUL_B_BITS-1:0]  mul_b;
   logic [VOL_BITS-1:0]    vol_eff;
   logic [TGT_BITS-1:0]    tgt_clamp;
   logic [GAIN_BITS-1:0]   tgt_q;
   logic [SAMPLE_BITS-1:0] s_raw;
   logic [48:0]            gsum;
   logic [56:0]            rsum;
   logic [24:0]            rmag;
   logic                   rsat;
   logic [63:0]            fsum;
   logic [FRAME_BITS-1:0]  frames_q;
   logic [STEP_BITS-1:0]   diff;
   logic [STEP_BITS-1:0]   diff_mag;
   logic [CHAN_BITS-1:0]   chans;
   logic [CHAN_BITS-1:0]   pos_plus;
   logic                   last;
   logic [FRAME_BITS-1:0]  frames_dec;
   logic [GAIN_BITS+1:0]   nxt;
   logic                   accept;
   logic                   out_free;

   agfr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      vol_eff = muted_ff ? '0 : ((vol_ff > UNITY_Q16) ? UNITY_Q16 : vol_ff);
      case (state_ff)
         ST_FMUL: begin
            mul_a = MUL_A_BITS'(rate_ff);
            mul_b = MUL_B_BITS'(ms_ff);
         end
         ST_FR0: begin
            mul_a = FRAME_RECIP[23:0];
            mul_b = fnum_ff[16:0];
         end
         ST_FR1: begin
            mul_a = FRAME_RECIP[23:0];
            mul_b = MUL_B_BITS'(fnum_ff[30:17]);
         end
         ST_FR2: begin
            mul_a = MUL_A_BITS'(FRAME_RECIP[31:24]);
            mul_b = fnum_ff[16:0];
         end
         ST_FR3: begin
            mul_a = MUL_A_BITS'(FRAME_RECIP[31:24]);
            mul_b = MUL_B_BITS'(fnum_ff[30:17]);
         end
         ST_G0: begin
            mul_a = MUL_A_BITS'(vol_eff);
            mul_b = cur_ff[16:0];
         end
         ST_G1: begin
            mul_a = MUL_A_BITS'(vol_eff);
            mul_b = MUL_B_BITS'(cur_ff[32:17]);
         end
         ST_M0: begin
            mul_a = mag_ff;
            mul_b = g_ff[16:0];
         end
         ST_M1: begin
            mul_a = mag_ff;
            mul_b = MUL_B_BITS'(g_ff[32:17]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      tgt_clamp  = (req_data.target_gain > UNITY_Q16) ? UNITY_Q16 : req_data.target_gain;
      tgt_q      = {tgt_clamp, 16'd0};
      s_raw      = req_data.sample_in;
      gsum       = 49'(acc_ff[33:0]) + (49'(prod_ff[32:0]) << 17) + 49'd32768;
      rsum       = 57'(acc_ff) + (57'(prod_ff[39:0]) << 17) + (57'd1 << 31);
      rmag       = rsum[56:32];
      rsat       = rmag >= 25'h0800000;
      fsum       = facc_ff + (64'(prod_ff) << 41);
      // rate*ms/1000 stays below 2^25, so the frame count never saturates.
      frames_q   = (fsum[63:FRAME_RECIP_SHIFT] == '0) ? FRAME_BITS'(1)
                                                     : FRAME_BITS'(fsum[63:FRAME_RECIP_SHIFT]);
      diff       = {1'b0, newt_ff} - {1'b0, cur_ff};
      diff_mag   = diff[STEP_BITS-1] ? (~diff + 1'b1) : diff;
      chans      = (chan_ff == '0) ? CHAN_BITS'(1)
                 : ((chan_ff > CHAN_BITS'(MAX_CHANNELS)) ? CHAN_BITS'(MAX_CHANNELS) : chan_ff);
      pos_plus   = {1'b0, pos_ff} + 1'b1;
      last       = pos_plus >= chans;
      frames_dec = frames_ff - 1'b1;
      nxt        = {2'b00, cur_ff} + {step_ff[STEP_BITS-1], step_ff};
   end

   always_comb begin
      state_in     = state_ff;
      rate_in      = rate_ff;
      chan_in      = chan_ff;
      vol_in       = vol_ff;
      muted_in     = muted_ff;
      playing_in   = playing_ff;
      cur_in       = cur_ff;
      target_in    = target_ff;
      step_in      = step_ff;
      frames_in    = frames_ff;
      pos_in       = pos_ff;
      newt_in      = newt_ff;
      ms_in        = ms_ff;
      newf_in      = newf_ff;
      fnum_in      = fnum_ff;
      facc_in      = facc_ff;
      sneg_in      = sneg_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      prod_in      = {{(PROD_BITS-MUL_A_BITS){1'b0}}, mul_a} *
                     {{(PROD_BITS-MUL_B_BITS){1'b0}}, mul_b};
      acc_in       = acc_ff;
      g_in         = g_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      div_req      = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_SAMPLE_RATE: rate_in    = csr_wdata[RATE_BITS-1:0];
            CSR_CHANNELS:    chan_in    = csr_wdata[CHAN_BITS-1:0];
            CSR_MASTER_VOL:  vol_in     = csr_wdata[VOL_BITS-1:0];
            CSR_MUTED:       muted_in   = csr_wdata[0];
            CSR_PLAYING:     playing_in = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.opcode == OP_SET_TARGET) begin
                  if (req_data.fade_ms == '0) begin
                     cur_in    = tgt_q;
                     target_in = tgt_q;
                     step_in   = '0;
                     frames_in = '0;
                  end else begin
                     newt_in  = tgt_q;
                     ms_in    = req_data.fade_ms;
                     state_in = ST_FMUL;
                  end
               end else begin
                  neg_in   = s_raw[SAMPLE_BITS-1];
                  mag_in   = s_raw[SAMPLE_BITS-1] ? (~s_raw + 1'b1) : s_raw;
                  state_in = ST_G0;
               end
            end
         end
         ST_FMUL: state_in = ST_FLD;
         ST_FLD: begin
            // 1000 = 8 * 125: the factor 8 goes by a shift, 125 by the reciprocal.
            fnum_in  = prod_ff[33:3];
            state_in = ST_FR0;
         end
         ST_FR0: state_in = ST_FR1;
         ST_FR1: begin
            facc_in  = 64'(prod_ff);
            state_in = ST_FR2;
         end
         ST_FR2: begin
            facc_in  = facc_ff + (64'(prod_ff) << 17);
            state_in = ST_FR3;
         end
         ST_FR3: begin
            facc_in  = facc_ff + (64'(prod_ff) << 24);
            state_in = ST_FR4;
         end
         ST_FR4: begin
            newf_in          = frames_q;
            sneg_in          = diff[STEP_BITS-1];
            div_req.start    = 1'b1;
            div_req.dividend = diff_mag;
            div_req.divisor  = frames_q;
            state_in         = ST_SWAIT;
         end
         ST_SWAIT: begin
            if (div_rsp.done) begin
               // Truncation toward zero keeps the ramp from overshooting.
               step_in   = sneg_ff ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;
               target_in = newt_ff;
               frames_in = newf_ff;
               state_in  = ST_IDLE;
            end
         end
         ST_G0: state_in = ST_G1;
         ST_G1: begin
            acc_in   = prod_ff;
            state_in = ST_G2;
         end
         ST_G2: begin
            g_in     = gsum[48:16];
            state_in = ST_M0;
         end
         ST_M0: state_in = ST_M1;
         ST_M1: begin
            acc_in   = prod_ff;
            state_in = ST_M2;
         end
         ST_M2: begin
            if (!neg_ff) begin
               y_in = rsat ? 24'h7FFFFF : rmag[SAMPLE_BITS-1:0];
            end else begin
               y_in = rsat ? 24'h800000 : (~rmag[SAMPLE_BITS-1:0] + 1'b1);
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               if (last) begin
                  pos_in = '0;
                  if (playing_ff && frames_ff != '0) begin
                     frames_in = frames_dec;
                     if (frames_dec == '0) begin
                        cur_in = target_ff;
                     end else if (nxt[GAIN_BITS+1]) begin
                        cur_in = '0;
                     end else if (nxt[GAIN_BITS:0] > {1'b0, GAIN_ONE}) begin
                        cur_in = GAIN_ONE;
                     end else begin
                        cur_in = nxt[GAIN_BITS-1:0];
                     end
                  end
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
               rsp_valid_in            = 1'b1;
               rsp_data_in.sample_out  = playing_ff ? y_ff : '0;
               rsp_data_in.frame_last  = last;
               rsp_data_in.ramp_active = frames_in != '0;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      newt_ff     <= newt_in;
      ms_ff       <= ms_in;
      newf_ff     <= newf_in;
      fnum_ff     <= fnum_in;
      facc_ff     <= facc_in;
      sneg_ff     <= sneg_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      g_ff        <= g_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= 18'd48000;
         chan_ff      <= 4'd2;
         vol_ff       <= UNITY_Q16;
         muted_ff     <= 1'b0;
         playing_ff   <= 1'b0;
         cur_ff       <= '0;
         target_ff    <= '0;
         step_ff      <= '0;
         frames_ff    <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         chan_ff      <= chan_in;
         vol_ff       <= vol_in;
         muted_ff     <= muted_in;
         playing_ff   <= playing_in;
         cur_ff       <= cur_in;
         target_ff    <= target_in;
         step_ff      <= step_in;
         frames_ff    <= frames_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/agfr_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the audio gain fade ramp and its bind to the top level.
// Depends on agfr_pkg and audio_gain_fade_ramp.
module agfr_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input agfr_pkg::agfr_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input agfr_pkg::agfr_rsp_type rsp_data
);
   import agfr_pkg::*;

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   // Reset empties the output register.
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A sample request or a fading set-target request keeps the block busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_data.opcode == OP_SAMPLE || req_data.fade_ms != '0) |=> !req_ready)
      else $error("request accepted without entering a busy phase");

   // A new response is only loaded while the block is working on a request.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared while idle");

endmodule

bind audio_gain_fade_ramp agfr_checker u_agfr_checker (.*);
